### sv/mbps_pkg.sv
`timescale 1ns / 1ps

package mbps_pkg;

  // Window depth and offset width of the reported match address.
  localparam int MaxPattern = 16;
  localparam int OffsetBits = 32;

  // Pattern storage is fixed by the register layout: two 64-bit words.
  localparam int PatBytes = 16;
  localparam int LenW     = 5;
  localparam int CountW   = 32;
  localparam int AddrW    = 64;
  localparam int IdxW     = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int CfgIdxW  = 3;

  localparam logic [AddrW-1:0] OffMask =
    (OffsetBits >= AddrW) ? {AddrW{1'b1}} : ((AddrW'(1) << OffsetBits) - AddrW'(1));

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow  = 3'd0,
    CfgPatHigh = 3'd1,
    CfgCare    = 3'd2,
    CfgLength  = 3'd3,
    CfgBase    = 3'd4
  } cfg_idx_e;

  // Compare setup shared by every cell of the window.
  typedef struct packed {
    logic [PatBytes-1:0][7:0] pattern;
    logic [PatBytes-1:0]      care;
    logic [LenW-1:0]          eff_len;   // already clamped to 1..MaxPattern
  } cmp_cfg_t;

endpackage

### sv/mbps_cell.sv
`timescale 1ns / 1ps

// One window slot: holds a byte and its fill flag, passes them to the older
// neighbor, and checks the incoming byte against its pattern position.
module mbps_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic                         clear_i,
  input  logic [mbps_pkg::IdxW-1:0]    pos_i,
  input  mbps_pkg::cmp_cfg_t           cfg_i,
  input  logic [7:0]                   byte_i,
  input  logic                         fill_i,
  output logic [7:0]                   byte_o,
  output logic                         fill_o,
  output logic                         ok_o
);

  logic [7:0]                  byte_q;
  logic                        fill_q;
  logic [mbps_pkg::LenW:0]     sum;
  logic                        active;
  logic [mbps_pkg::IdxW-1:0]   pat_idx;
  logic [mbps_pkg::LenW:0]     pat_pos;
  logic [7:0]                  pat_byte;
  logic                        care;

  // Slot pos maps to pattern byte pos + len - MaxPattern when in use.
  assign sum      = (mbps_pkg::LenW+1)'(pos_i) + (mbps_pkg::LenW+1)'(cfg_i.eff_len);
  assign active   = (sum >= (mbps_pkg::LenW+1)'(mbps_pkg::MaxPattern));
  assign pat_pos  = sum - (mbps_pkg::LenW+1)'(mbps_pkg::MaxPattern);
  assign pat_idx  = pat_pos[mbps_pkg::IdxW-1:0];
  assign pat_byte = cfg_i.pattern[pat_idx];
  assign care     = cfg_i.care[pat_idx];

  assign ok_o = !active || (fill_i && (!care || (byte_i == pat_byte)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 1'b0;
    end else if (clear_i) begin
      fill_q <= 1'b0;
    end else if (shift_i) begin
      fill_q <= fill_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign fill_o = fill_q;

endmodule

### sv/masked_byte_pattern_scan_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// ------    ---  ------------------------  ---------------------------------
// in        in   in_valid_i / in_stall_o   data_byte_i, last_byte_i
// out       out  out_valid_o / out_stall_i found_o, match_address_o
// cfg       in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle is taken while the pipeline is not backed up; the
// sustained rate is one byte per clock, set by the window shift and the
// parallel compare across all cells.
// A result is registered after the compare (s1) and again after the
// address add (out stage); a stalled output can hold it in s1.
// Reset clears fill flags, counters and valids; registers return to their
// documented defaults. in_stall_o rises only when both result stages are
// full and out_stall_i is high. cfg_ready_o is always high.

module masked_byte_pattern_scan_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte stream
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [mbps_pkg::AddrW-1:0]        match_address_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbps_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [63:0]                       cfg_data_i
);

  localparam int N = mbps_pkg::MaxPattern;

  // ---------------- configuration registers ----------------
  logic [63:0]                 pat_low_q, pat_high_q;
  logic [15:0]                 care_q;
  logic [mbps_pkg::LenW-1:0]   len_q;
  logic [mbps_pkg::AddrW-1:0]  base_q;
  logic                        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= 16'hFFFF;
      len_q      <= mbps_pkg::LenW'(1);
      base_q     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        mbps_pkg::CfgPatLow:  pat_low_q  <= cfg_data_i;
        mbps_pkg::CfgPatHigh: pat_high_q <= cfg_data_i;
        mbps_pkg::CfgCare:    care_q     <= cfg_data_i[15:0];
        mbps_pkg::CfgLength:  len_q      <= cfg_data_i[mbps_pkg::LenW-1:0];
        mbps_pkg::CfgBase:    base_q     <= cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Clamp length: zero acts as one, oversize acts as full window.
  logic [mbps_pkg::LenW-1:0] eff_len;
  always_comb begin
    priority if (len_q == '0) begin
      eff_len = mbps_pkg::LenW'(1);
    end else if (len_q > mbps_pkg::LenW'(N)) begin
      eff_len = mbps_pkg::LenW'(N);
    end else begin
      eff_len = len_q;
    end
  end

  mbps_pkg::cmp_cfg_t cmp_cfg;
  assign cmp_cfg.pattern = {pat_high_q, pat_low_q};
  assign cmp_cfg.care    = care_q;
  assign cmp_cfg.eff_len = eff_len;

  // ---------------- handshake and result stages ----------------
  // s1: compare result and raw offset. out: final word with address.
  logic                         s1_valid_q, s1_valid_d;
  logic                         s1_found_q, s1_found_d;
  logic [mbps_pkg::CountW-1:0]  s1_off_q,   s1_off_d;
  logic                         out_valid_q, out_valid_d;
  logic                         found_q;
  logic [mbps_pkg::AddrW-1:0]   addr_q;
  logic                         out_adv, s1_move, s1_free, accept;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_adv;
  assign s1_free    = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  // ---------------- window: chain of cells ----------------
  // Slot N-1 holds the newest byte; the chain input is the arriving byte.
  logic [7:0] win_byte [N+1];
  logic       win_fill [N+1];
  logic [N-1:0] cell_ok;
  logic       match_done_q, match_done_d;
  logic       shift, clear;

  assign win_byte[N] = data_byte_i;
  assign win_fill[N] = 1'b1;
  assign shift = accept && !match_done_q;
  assign clear = accept && last_byte_i;

  for (genvar k = 0; k < N; k++) begin : g_cell
    mbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clear_i (clear),
      .pos_i   (mbps_pkg::IdxW'(k)),
      .cfg_i   (cmp_cfg),
      .byte_i  (win_byte[k+1]),
      .fill_i  (win_fill[k+1]),
      .byte_o  (win_byte[k]),
      .fill_o  (win_fill[k]),
      .ok_o    (cell_ok[k])
    );
  end

  // ---------------- region tracking ----------------
  logic [mbps_pkg::CountW-1:0] seen_q, seen_d, seen_inc;
  logic                        hit;

  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + mbps_pkg::CountW'(1);
  // all active cells filled and matching
  assign hit = &cell_ok;

  always_comb begin
    seen_d       = seen_q;
    match_done_d = match_done_q;
    s1_valid_d   = s1_move ? 1'b0 : s1_valid_q;
    s1_found_d   = s1_found_q;
    s1_off_d     = s1_off_q;
    if (shift) begin
      seen_d = seen_inc;
      if (hit) begin
        match_done_d = 1'b1;
        s1_valid_d   = 1'b1;
        s1_found_d   = 1'b1;
        s1_off_d     = seen_inc - mbps_pkg::CountW'(eff_len);
      end else if (last_byte_i) begin
        s1_valid_d = 1'b1;
        s1_found_d = 1'b0;
        s1_off_d   = '0;
      end
    end
    if (clear) begin
      seen_d       = '0;
      match_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      match_done_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      seen_q       <= seen_d;
      match_done_q <= match_done_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_found_q <= s1_found_d;
    s1_off_q   <= s1_off_d;
  end

  // ---------------- output stage: address add ----------------
  assign out_valid_d = s1_move ? 1'b1 : (out_adv ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      found_q <= s1_found_q;
      addr_q  <= s1_found_q
               ? base_q + (mbps_pkg::AddrW'(s1_off_q) & mbps_pkg::OffMask)
               : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

endmodule
